// ----- rtl/core/scanline_flood_fill_defines.svh -----
// Assertion helpers for the flood fill block.
`ifndef SCANLINE_FLOOD_FILL_DEFINES_SVH
`define SCANLINE_FLOOD_FILL_DEFINES_SVH

// same-cycle implication
`define SFF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SFF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/sff_pkg.sv -----
package sff_pkg;

	localparam int IMG_W       = 256;
	localparam int IMG_H       = 256;
	localparam int IMG_AW      = 16;
	localparam int STACK_DEPTH = 1024;
	localparam int STK_AW      = $clog2(STACK_DEPTH);
	localparam int SP_W        = STK_AW + 1;
	localparam int CNT_W       = 17;

	// compare mask for 16-bit mode: each lane shifted right by 7
	localparam logic [63:0] LANE_MASK = 64'hFF80_FF80_FF80_FF80;

	localparam logic [1:0] MODE_WR   = 2'd0;
	localparam logic [1:0] MODE_RD   = 2'd1;
	localparam logic [1:0] MODE_FILL = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_NONE = 2'd1;
	localparam logic [1:0] STAT_OVF  = 2'd2;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_DEPTH  = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [63:0] pixel;
	} in_t;

	typedef struct packed {
		logic [63:0]      pixel_out;
		logic [1:0]       status;
		logic [CNT_W-1:0] filled_count;
	} out_t;

	typedef struct packed {
		logic [7:0] x1;
		logic [7:0] x2;
		logic [7:0] y;
		logic       down;
	} span_t;

endpackage

// ----- rtl/core/scanline_flood_fill.sv -----
// Channel | Dir | Handshake            | Payload
// in      | in  | in_valid / in_stall   | in_data  (in_t: mode, x, y, pixel)
// out     | out | out_valid / out_stall | out_data (out_t: pixel_out, status, filled_count)
// cfg     | in  | cfg_we               | cfg_index, cfg_wdata
//
// Write and read requests go from idle straight to the final state; mode three likewise.
// A fill visits pixels one at a time through one shared image port and one
// compare unit.
// Reset clears control state only; image and span store hold garbage until written.
// A finished result waits in the output register while out_stall is high; a new
// request is taken meanwhile, and its result waits in the final state.
`include "scanline_flood_fill_defines.svh"

module scanline_flood_fill import sff_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_t       out_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_wdata
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_SEED  = 5'd1;
	localparam logic [4:0] S_PUSH2 = 5'd2;
	localparam logic [4:0] S_POP   = 5'd3;
	localparam logic [4:0] S_POPW  = 5'd4;
	localparam logic [4:0] S_LRD   = 5'd5;
	localparam logic [4:0] S_LCHK  = 5'd6;
	localparam logic [4:0] S_RRD   = 5'd7;
	localparam logic [4:0] S_RCHK  = 5'd8;
	localparam logic [4:0] S_SINIT = 5'd9;
	localparam logic [4:0] S_SRD   = 5'd10;
	localparam logic [4:0] S_SCHK  = 5'd11;
	localparam logic [4:0] S_STAIL = 5'd12;
	localparam logic [4:0] S_SEND  = 5'd13;
	localparam logic [4:0] S_KRD   = 5'd14;
	localparam logic [4:0] S_KCHK  = 5'd15;
	localparam logic [4:0] S_DONE  = 5'd16;

	localparam logic [8:0] MAX_W9 = 9'(IMG_W);
	localparam logic [8:0] MAX_H9 = 9'(IMG_H);

	// configuration
	logic [8:0] width_q, height_q;
	logic       depth_q;
	logic [8:0] eff_w, eff_h;

	// sequencer
	logic [4:0]       state_q;
	logic [1:0]       mode_q;
	logic [1:0]       stat_q;
	logic             ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic [63:0]      fcol_q, tgt_q;
	logic [7:0]       x1_q, x2_q, y_q;
	logic             down_q;
	logic [8:0]       x_q;
	logic [7:0]       left_q, right_q;
	logic             ph_q;
	logic [7:0]       ny_q, i_q, start_q;
	logic             in_run_q;
	logic             up_q;
	logic [SP_W-1:0]  sp_q;

	// output register
	logic out_valid_q;
	out_t out_q;

	// memories
	logic [63:0]       img_mem [IMG_W*IMG_H];
	logic [63:0]       img_rdata;
	logic [IMG_AW-1:0] img_addr;
	logic              img_re, img_we;
	logic [63:0]       img_wdata;

	logic [24:0]       stk_mem [STACK_DEPTH];
	span_t             stk_rdata;
	logic [STK_AW-1:0] stk_raddr;
	logic              stk_re;

	logic       push_req;
	span_t      push_span;
	logic       accept;
	logic       match;
	logic [63:0] cmp_b;
	logic       up_now;
	logic [9:0] ny_calc;
	logic       ny_ok;
	logic       take_out;

	assign eff_w = (width_q == 9'd0) ? 9'd1 : ((width_q > MAX_W9) ? MAX_W9 : width_q);
	assign eff_h = (height_q == 9'd0) ? 9'd1 : ((height_q > MAX_H9) ? MAX_H9 : height_q);

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign take_out  = !out_valid_q || !out_stall;

	// shared compare unit; the seed is checked against the fill colour
	assign cmp_b = (state_q == S_SEED) ? fcol_q : tgt_q;

	sff_match u_match (
		.a    (img_rdata),
		.b    (cmp_b),
		.depth(depth_q),
		.match(match)
	);

	// neighbour row: phase 0 goes the span's way, phase 1 the other
	assign up_now  = ph_q ? !down_q : down_q;
	assign ny_calc = up_now ? ({2'b00, y_q} + 10'd1) : ({2'b00, y_q} - 10'd1);
	assign ny_ok   = up_now ? (ny_calc[8:0] < eff_h)
	                        : ((y_q != 8'd0) && (ny_calc[8:0] < eff_h));

	// image port
	always_comb begin
		if (state_q == S_IDLE) begin
			img_addr = {in_data.y, in_data.x};
		end else if (state_q == S_SRD) begin
			img_addr = {ny_q, i_q};
		end else begin
			img_addr = {y_q, x_q[7:0]};
		end
		img_re = accept || (state_q == S_LRD) || (state_q == S_RRD) ||
		         (state_q == S_SRD) || (state_q == S_KRD);
		img_we = (accept && (in_data.mode == MODE_WR)) ||
		         (((state_q == S_LCHK) || (state_q == S_RCHK)) && match);
		img_wdata = (state_q == S_IDLE) ? in_data.pixel : fcol_q;
	end

	always_ff @(posedge clk) begin
		if (img_we) begin
			img_mem[img_addr] <= img_wdata;
		end
		if (img_re) begin
			img_rdata <= img_mem[img_addr];
		end
	end

	// span pushes
	always_comb begin
		push_req  = 1'b0;
		push_span = '{x1: x1_q, x2: x1_q, y: y_q, down: 1'b1};
		unique case (state_q)
			S_SEED: begin
				push_req = !match;
			end
			S_PUSH2: begin
				push_req  = 1'b1;
				push_span = '{x1: x1_q, x2: x1_q, y: y_q - 8'd1, down: 1'b0};
			end
			S_SCHK: begin
				push_req  = in_run_q && !match;
				push_span = '{x1: start_q, x2: i_q - 8'd1, y: ny_q, down: up_q};
			end
			S_STAIL: begin
				push_req  = in_run_q;
				push_span = '{x1: start_q, x2: right_q, y: ny_q, down: up_q};
			end
			default: begin
				push_req = 1'b0;
			end
		endcase
	end

	assign stk_re    = (state_q == S_POP) && (sp_q != '0);
	assign stk_raddr = STK_AW'(sp_q - SP_W'(1));

	always_ff @(posedge clk) begin
		if (push_req && (sp_q < SP_W'(STACK_DEPTH))) begin
			stk_mem[sp_q[STK_AW-1:0]] <= push_span;
		end
		if (stk_re) begin
			stk_rdata <= stk_mem[stk_raddr];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= MAX_W9;
			height_q <= MAX_H9;
			depth_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_wdata;
				CFG_HEIGHT: height_q <= cfg_wdata;
				CFG_DEPTH:  depth_q  <= cfg_wdata[0];
				default:    ;
			endcase
		end
	end

	// stack pointer and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q  <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			ovf_q <= 1'b0;
		end else if (stk_re) begin
			sp_q <= sp_q - SP_W'(1);
		end else if (push_req) begin
			if (sp_q < SP_W'(STACK_DEPTH)) begin
				sp_q <= sp_q + SP_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// output register: loaded from the final state, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if ((state_q == S_DONE) && take_out) begin
			out_valid_q <= 1'b1;
			out_q       <= '{pixel_out: (mode_q == MODE_RD) ? img_rdata : 64'd0,
			                 status: (mode_q == MODE_FILL) ? stat_q : STAT_OK,
			                 filled_count: (mode_q == MODE_FILL) ? cnt_q : {CNT_W{1'b0}}};
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tgt_q       <= '0;
			cnt_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q <= in_data.mode;
						fcol_q <= in_data.pixel;
						x1_q   <= in_data.x;
						y_q    <= in_data.y;
						cnt_q  <= '0;
						if (in_data.mode == MODE_FILL) begin
							if (({1'b0, in_data.x} >= eff_w) ||
							    ({1'b0, in_data.y} >= eff_h)) begin
								stat_q  <= STAT_NONE;
								state_q <= S_DONE;
							end else begin
								stat_q  <= STAT_OK;
								state_q <= S_SEED;
							end
						end else begin
							stat_q  <= STAT_OK;
							state_q <= S_DONE;
						end
					end
				end
				S_SEED: begin
					tgt_q <= img_rdata;
					if (match) begin
						stat_q  <= STAT_NONE;
						state_q <= S_DONE;
					end else if (y_q != 8'd0) begin
						state_q <= S_PUSH2;
					end else begin
						state_q <= S_POP;
					end
				end
				S_PUSH2: begin
					state_q <= S_POP;
				end
				S_POP: begin
					if (sp_q == '0) begin
						stat_q  <= ovf_q ? STAT_OVF : STAT_OK;
						state_q <= S_DONE;
					end else begin
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					x1_q    <= stk_rdata.x1;
					x2_q    <= stk_rdata.x2;
					y_q     <= stk_rdata.y;
					down_q  <= stk_rdata.down;
					x_q     <= {1'b0, stk_rdata.x1};
					state_q <= S_LRD;
				end
				S_LRD: begin
					state_q <= S_LCHK;
				end
				S_LCHK: begin
					if (match) begin
						if (cnt_q != {CNT_W{1'b1}}) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (x_q == 9'd0) begin
							left_q  <= 8'd0;
							x_q     <= {1'b0, x1_q} + 9'd1;
							state_q <= S_RRD;
						end else begin
							x_q     <= x_q - 9'd1;
							state_q <= S_LRD;
						end
					end else if (x_q[7:0] == x1_q) begin
						state_q <= S_POP;
					end else begin
						left_q  <= x_q[7:0] + 8'd1;
						x_q     <= {1'b0, x1_q} + 9'd1;
						state_q <= S_RRD;
					end
				end
				S_RRD: begin
					if (x_q < eff_w) begin
						state_q <= S_RCHK;
					end else begin
						right_q <= 8'(x_q - 9'd1);
						ph_q    <= 1'b0;
						state_q <= S_SINIT;
					end
				end
				S_RCHK: begin
					if (match) begin
						if (cnt_q != {CNT_W{1'b1}}) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						x_q     <= x_q + 9'd1;
						state_q <= S_RRD;
					end else begin
						right_q <= 8'(x_q - 9'd1);
						ph_q    <= 1'b0;
						state_q <= S_SINIT;
					end
				end
				S_SINIT: begin
					ny_q     <= ny_calc[7:0];
					up_q     <= up_now;
					i_q      <= left_q;
					in_run_q <= 1'b0;
					state_q  <= ny_ok ? S_SRD : S_SEND;
				end
				S_SRD: begin
					state_q <= S_SCHK;
				end
				S_SCHK: begin
					if (!in_run_q && match) begin
						start_q  <= i_q;
						in_run_q <= 1'b1;
					end else if (in_run_q && !match) begin
						in_run_q <= 1'b0;
					end
					if (i_q == right_q) begin
						state_q <= S_STAIL;
					end else begin
						i_q     <= i_q + 8'd1;
						state_q <= S_SRD;
					end
				end
				S_STAIL: begin
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (!ph_q) begin
						ph_q    <= 1'b1;
						state_q <= S_SINIT;
					end else begin
						state_q <= S_KRD;
					end
				end
				S_KRD: begin
					if ((x_q <= {1'b0, x2_q}) && (x_q < eff_w)) begin
						state_q <= S_KCHK;
					end else begin
						state_q <= S_POP;
					end
				end
				S_KCHK: begin
					if (match) begin
						left_q  <= x_q[7:0];
						state_q <= S_RRD;
					end else begin
						x_q     <= x_q + 9'd1;
						state_q <= S_KRD;
					end
				end
				S_DONE: begin
					if (take_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SFF_ASSERT_NXT(a_accept_busy, accept, (state_q != S_IDLE), "request not taken up")
	`SFF_ASSERT_IMP(a_stack_empty_done, (state_q == S_DONE), (sp_q == '0), "stack not empty")
	`SFF_ASSERT_NXT(a_ovf_flag, (push_req && (sp_q == SP_W'(STACK_DEPTH))), ovf_q, "overflow lost")

endmodule

// ----- rtl/core/sff_match.sv -----
// Colour compare: whole word, or bits 7 and above of each lane in 16-bit mode.
module sff_match import sff_pkg::*; (
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic        depth,
	output logic        match
);

	logic [63:0] diff;

	assign diff  = a ^ b;
	assign match = depth ? ((diff & LANE_MASK) == 64'd0) : (diff == 64'd0);

endmodule
